// ===== hdl/heds_pkg.sv =====
// ----------------------------------------------------------------------------
// heds_pkg
// Shared constants, types and helpers of the equal-depth histogram splitter.
// ----------------------------------------------------------------------------
package heds_pkg;

  localparam int NUM_BINS  = 65536;
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int VALUE_W   = 16;
  localparam int CNT_W     = 32;
  localparam int MAX_PARTS = 64;
  localparam int NP_W      = 7;
  localparam int PART_W    = 6;
  localparam int PROD_W    = CNT_W + NP_W;
  localparam int DP_W      = CNT_W + BIN_W + NP_W;

  localparam logic [BIN_W-1:0] TOP_BIN = BIN_W'(NUM_BINS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // one write request into the histogram memory
  typedef struct packed {
    logic             we;
    logic [BIN_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } ram_wr_t;

  // values past the last bin land in the top bin
  function automatic logic [BIN_W-1:0] bin_of(input logic [VALUE_W-1:0] value);
    logic [BIN_W-1:0] res;
    if (int'(value) >= NUM_BINS) begin
      res = TOP_BIN;
    end else begin
      res = BIN_W'(value);
    end
    return res;
  endfunction

endpackage

// ===== hdl/heds_ram.sv =====
// ----------------------------------------------------------------------------
// heds_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module heds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/heds_count.sv =====
// ----------------------------------------------------------------------------
// heds_count
// Sample path: read-modify-write of one histogram bin per beat with
// forwarding, plus the saturating sample total.
// ----------------------------------------------------------------------------
module heds_count (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample,
  input  logic [heds_pkg::VALUE_W-1:0] value,
  input  logic                         total_clear,
  input  logic [heds_pkg::CNT_W-1:0]   rd_data,
  output logic [heds_pkg::BIN_W-1:0]   raddr,
  output heds_pkg::ram_wr_t            wr,
  output logic [heds_pkg::CNT_W-1:0]   total
);

  logic                       s1_v;
  logic [heds_pkg::BIN_W-1:0] s1_addr;
  logic                       fw_v;
  logic [heds_pkg::BIN_W-1:0] fw_addr;
  logic [heds_pkg::CNT_W-1:0] fw_data;
  logic [heds_pkg::CNT_W-1:0] cur;
  logic [heds_pkg::CNT_W-1:0] cnt_next;

  assign raddr = heds_pkg::bin_of(value);

  always_comb begin
    // the read of this beat missed the write of the beat just before it
    cur = (fw_v && fw_addr == s1_addr) ? fw_data : rd_data;
    cnt_next = (cur == heds_pkg::CNT_MAX) ? cur : cur + 1'b1;
    wr.we   = s1_v;
    wr.addr = s1_addr;
    wr.data = cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      fw_v  <= 1'b0;
      total <= '0;
    end else begin
      s1_v <= sample;
      fw_v <= s1_v;
      if (total_clear) begin
        total <= '0;
      end else if (sample && total != heds_pkg::CNT_MAX) begin
        total <= total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= raddr;
    fw_addr <= s1_addr;
    fw_data <= cnt_next;
  end

endmodule

// ===== hdl/heds_walk.sv =====
// ----------------------------------------------------------------------------
// heds_walk
// Sequential scan of the histogram memory: reads and zeroes one bin per
// cycle, runs the cumulative partition search and emits the ranges.
// ----------------------------------------------------------------------------
module heds_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         finish,
  input  logic [heds_pkg::NP_W-1:0]    num_parts,
  input  logic [heds_pkg::CNT_W-1:0]   total,
  input  logic [heds_pkg::CNT_W-1:0]   rd_data,
  output logic                         busy,
  output logic                         total_clear,
  output logic [heds_pkg::BIN_W-1:0]   raddr,
  output heds_pkg::ram_wr_t            wr,
  output logic                         result_valid,
  output logic [heds_pkg::PART_W-1:0]  part_index,
  output logic [heds_pkg::VALUE_W-1:0] lower_bound,
  output logic [heds_pkg::VALUE_W-1:0] upper_bound,
  output logic                         empty_part,
  output logic                         last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } walk_state_t;

  walk_state_t                 state;
  logic                        walk_mode;
  logic [heds_pkg::BIN_W-1:0]  scan_addr;
  logic                        rd_v;
  logic [heds_pkg::BIN_W-1:0]  rd_addr;
  logic                        s2_v;
  logic [heds_pkg::BIN_W-1:0]  s2_addr;
  logic [heds_pkg::PROD_W-1:0] prod;
  logic [heds_pkg::NP_W-1:0]   p;
  logic [heds_pkg::NP_W-1:0]   part;
  logic [heds_pkg::BIN_W:0]    lower;
  logic [heds_pkg::DP_W-1:0]   dp;
  logic                        exhausted;

  logic                        issue;
  logic                        searching;
  logic                        at_lower;
  logic [heds_pkg::DP_W-1:0]   dp_sum;
  logic                        hit;
  logic                        proc_bin;
  logic                        s_emit;
  logic                        e_emit;
  logic                        flushed;
  logic [heds_pkg::NP_W-1:0]   p_clamped;

  always_comb begin
    issue     = (state == ST_SCAN);
    searching = walk_mode && !exhausted && (heds_pkg::NP_W'(part + 1'b1) < p);
    at_lower  = ({1'b0, s2_addr} == lower);
    // dp tracks (C(u) - C(lower)) * P, so the test reduces to dp >= total
    dp_sum    = at_lower ? '0 : dp + heds_pkg::DP_W'(prod);
    hit       = dp_sum >= heds_pkg::DP_W'(total);
    proc_bin  = s2_v && searching;
    s_emit    = proc_bin && (hit || s2_addr == heds_pkg::TOP_BIN);
    e_emit    = walk_mode && state != ST_IDLE && !searching && part < p;
    flushed   = !rd_v && !s2_v && (!walk_mode || part == p);
    if (num_parts == '0) begin
      p_clamped = heds_pkg::NP_W'(1);
    end else if (int'(num_parts) > heds_pkg::MAX_PARTS) begin
      p_clamped = heds_pkg::NP_W'(heds_pkg::MAX_PARTS);
    end else begin
      p_clamped = num_parts;
    end
    busy        = (state != ST_IDLE);
    total_clear = (state == ST_FLUSH) && flushed && walk_mode;
    raddr       = scan_addr;
    wr.we       = issue;
    wr.addr     = scan_addr;
    wr.data     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SCAN;
      walk_mode    <= 1'b0;
      scan_addr    <= '0;
      rd_v         <= 1'b0;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
      p            <= heds_pkg::NP_W'(1);
      part         <= '0;
      lower        <= '0;
      exhausted    <= 1'b0;
    end else begin
      rd_v         <= issue;
      s2_v         <= rd_v;
      result_valid <= s_emit || e_emit;
      unique case (state)
        ST_IDLE: begin
          if (finish) begin
            state     <= ST_SCAN;
            walk_mode <= 1'b1;
            scan_addr <= '0;
            p         <= p_clamped;
            part      <= '0;
            lower     <= '0;
            exhausted <= 1'b0;
          end
        end
        ST_SCAN: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == heds_pkg::TOP_BIN) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (flushed) begin
            state     <= ST_IDLE;
            walk_mode <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (s_emit) begin
        part <= part + 1'b1;
        if (hit) begin
          lower <= {1'b0, s2_addr} + 1'b1;
        end
        if (s2_addr == heds_pkg::TOP_BIN) begin
          exhausted <= 1'b1;
        end
      end else if (e_emit) begin
        part <= part + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= scan_addr;
    s2_addr <= rd_addr;
    prod    <= heds_pkg::PROD_W'(rd_data) * heds_pkg::PROD_W'(p);
    if (proc_bin) begin
      dp <= dp_sum;
    end
    if (s_emit) begin
      part_index  <= heds_pkg::PART_W'(part);
      lower_bound <= heds_pkg::VALUE_W'(lower);
      upper_bound <= heds_pkg::VALUE_W'(s2_addr);
      empty_part  <= 1'b0;
      last        <= 1'b0;
    end else if (e_emit) begin
      part_index  <= heds_pkg::PART_W'(part);
      lower_bound <= exhausted ? heds_pkg::VALUE_W'(heds_pkg::TOP_BIN)
                               : heds_pkg::VALUE_W'(lower);
      upper_bound <= heds_pkg::VALUE_W'(heds_pkg::TOP_BIN);
      empty_part  <= exhausted;
      last        <= (heds_pkg::NP_W'(part + 1'b1) == p);
    end
  end

endmodule

// ===== hdl/histogram_equal_depth_splitter.sv =====
// ----------------------------------------------------------------------------
// histogram_equal_depth_splitter
// Equal-depth partitioning over a memory-held histogram of sample values.
// ----------------------------------------------------------------------------
// sample beats: one per cycle while busy is low, no result; bin update is a registered
//   read-modify-write on the histogram memory with write-to-read forwarding
// finish beat: busy while the scan runs and while any ranges still owed when the scan
//   drains are emitted; ranges come out as the scan passes
// reset: busy while the scan zeroes the memory
// results appear for one cycle on result_valid and cannot be stalled
module histogram_equal_depth_splitter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [heds_pkg::VALUE_W-1:0] value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [heds_pkg::NP_W-1:0]    cfg_data,
  output logic                         result_valid,
  output logic [heds_pkg::PART_W-1:0]  part_index,
  output logic [heds_pkg::VALUE_W-1:0] lower_bound,
  output logic [heds_pkg::VALUE_W-1:0] upper_bound,
  output logic                         empty_part,
  output logic                         last
);

  logic [heds_pkg::NP_W-1:0]  num_parts;
  logic                       accept;
  logic                       total_clear;
  logic [heds_pkg::CNT_W-1:0] total;
  logic [heds_pkg::CNT_W-1:0] rd_data;
  logic [heds_pkg::BIN_W-1:0] cnt_raddr;
  logic [heds_pkg::BIN_W-1:0] walk_raddr;
  logic [heds_pkg::BIN_W-1:0] ram_raddr;
  heds_pkg::ram_wr_t          cnt_wr;
  heds_pkg::ram_wr_t          walk_wr;
  heds_pkg::ram_wr_t          ram_wr;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_parts <= heds_pkg::NP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      num_parts <= cfg_data;
    end
  end

  // the last sample write never overlaps the scan, so a priority mux will do
  always_comb begin
    ram_raddr = busy ? walk_raddr : cnt_raddr;
    ram_wr    = cnt_wr.we ? cnt_wr : walk_wr;
  end

  heds_ram #(
    .WIDTH (heds_pkg::CNT_W),
    .DEPTH (heds_pkg::NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  heds_count u_count (
    .clk         (clk),
    .rst         (rst),
    .sample      (accept && !kind),
    .value       (value),
    .total_clear (total_clear),
    .rd_data     (rd_data),
    .raddr       (cnt_raddr),
    .wr          (cnt_wr),
    .total       (total)
  );

  heds_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .finish       (accept && kind),
    .num_parts    (num_parts),
    .total        (total),
    .rd_data      (rd_data),
    .busy         (busy),
    .total_clear  (total_clear),
    .raddr        (walk_raddr),
    .wr           (walk_wr),
    .result_valid (result_valid),
    .part_index   (part_index),
    .lower_bound  (lower_bound),
    .upper_bound  (upper_bound),
    .empty_part   (empty_part),
    .last         (last)
  );

endmodule
